// ===== rtl/srd_pkg.sv =====
// Package: shared types for the sprite cel run-length decoder.
package srd_pkg;

	typedef enum logic [2:0] {
		PH_WIDTH,
		PH_HEIGHT,
		PH_FLAGS,
		PH_ROWS,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		K_WIDTH,
		K_FLAGS,
		K_RUN,
		K_FILL
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic [7:0] row;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic [7:0] run_x;
		logic [7:0] run_y;
		logic [7:0] run_length;
		logic [3:0] run_color;
		logic       is_fill;
		logic       row_end;
		logic       last_of_cel;
		logic       clipped;
	} res_t;

	localparam logic [7:0] COLOR_MASK = 8'hF0;
	localparam logic [7:0] NIB_MASK   = 8'h0F;
	localparam int         MIRROR_BIT = 7;

endpackage

// ===== rtl/srd_front.sv =====
// Front end: header parsing, row counting and classification of each byte.
module srd_front
	import srd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic [7:0] data_byte,
	input  logic       cel_start,
	output logic       cmd_push,
	output cmd_t       cmd
);

	phase_t     phase_q, phase_d, ph;
	logic [7:0] height_q, height_d;
	logic [7:0] row_q, row_d;
	logic       accept;
	logic       last_row;

	assign accept   = push && !full;
	assign last_row = ({1'b0, row_q} + 9'd1) == {1'b0, height_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_WIDTH;
			height_q <= '0;
			row_q    <= '0;
		end else begin
			phase_q  <= phase_d;
			height_q <= height_d;
			row_q    <= row_d;
		end
	end

	always_comb begin
		ph        = cel_start ? PH_WIDTH : phase_q;
		phase_d   = phase_q;
		height_d  = height_q;
		row_d     = row_q;
		cmd_push  = 1'b0;
		cmd.kind  = K_RUN;
		cmd.data  = data_byte;
		cmd.row   = row_q;
		cmd.last  = 1'b0;
		if (accept) begin
			case (ph)
				PH_WIDTH: begin
					cmd_push = 1'b1;
					cmd.kind = K_WIDTH;
					row_d    = '0;
					phase_d  = PH_HEIGHT;
				end
				PH_HEIGHT: begin
					height_d = data_byte;
					phase_d  = PH_FLAGS;
				end
				PH_FLAGS: begin
					cmd_push = 1'b1;
					cmd.kind = K_FLAGS;
					row_d    = '0;
					phase_d  = (height_q == 8'd0) ? PH_DONE : PH_ROWS;
				end
				PH_ROWS: begin
					cmd_push = 1'b1;
					if (data_byte != 8'd0) begin
						cmd.kind = K_RUN;
					end else begin
						cmd.kind = K_FILL;
						cmd.last = last_row;
						row_d    = row_q + 8'd1;
						if (last_row) begin
							phase_d = PH_DONE;
						end
					end
				end
				default: begin
					phase_d = ph;
				end
			endcase
		end
	end

endmodule

// ===== rtl/srd_cmd_queue.sv =====
// Two-entry queue of classified items between front and back end.
module srd_cmd_queue
	import srd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t cmd_in,
	output logic full,
	input  logic pop,
	output logic valid,
	output cmd_t cmd_out
);

	cmd_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign full    = cnt_q == 2'd2;
	assign valid   = cnt_q != 2'd0;
	assign do_push = push && !full;
	assign do_pop  = pop && valid;
	assign cmd_out = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

// ===== rtl/srd_back.sv =====
// Back end: column tracking, clipping, mirroring and the result queue.
module srd_back
	import srd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic loop_mirrored,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	output logic empty,
	input  logic pop,
	output res_t res
);

	logic [7:0] width_q, column_q;
	logic [3:0] transp_q;
	logic       mflag_q;
	res_t       out_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic [7:0] remain, nib, len;
	logic       clip, res_push, res_pop;
	res_t       r;

	assign cmd_pop  = cmd_valid && (cnt_q != 2'd2);
	assign res_push = cmd_pop && (cmd.kind == K_RUN || cmd.kind == K_FILL);
	assign empty    = cnt_q == 2'd0;
	assign res_pop  = pop && !empty;
	assign res      = out_q[rd_ptr_q];

	always_comb begin
		remain = width_q - column_q;
		nib    = cmd.data & NIB_MASK;
		clip   = 1'b0;
		if (cmd.kind == K_FILL) begin
			len = remain;
		end else if (nib > remain) begin
			len  = remain;
			clip = 1'b1;
		end else begin
			len = nib;
		end
		r.run_x       = (mflag_q && loop_mirrored) ? (remain - len) : column_q;
		r.run_y       = cmd.row;
		r.run_length  = len;
		r.run_color   = (cmd.kind == K_FILL) ? transp_q : 4'((cmd.data & COLOR_MASK) >> 4);
		r.is_fill     = cmd.kind == K_FILL;
		r.row_end     = cmd.kind == K_FILL;
		r.last_of_cel = cmd.last;
		r.clipped     = clip;
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			out_q[wr_ptr_q] <= r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= '0;
			column_q <= '0;
			transp_q <= '0;
			mflag_q  <= 1'b0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (cmd_pop) begin
				case (cmd.kind)
					K_WIDTH: begin
						width_q  <= cmd.data;
						column_q <= '0;
					end
					K_FLAGS: begin
						transp_q <= cmd.data[3:0];
						mflag_q  <= cmd.data[MIRROR_BIT];
						column_q <= '0;
					end
					K_RUN: begin
						column_q <= column_q + len;
					end
					K_FILL: begin
						column_q <= '0;
					end
					default: begin
						column_q <= column_q;
					end
				endcase
			end
			if (res_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (res_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, res_push} - {1'b0, res_pop};
		end
	end

endmodule

// ===== rtl/sprite_cel_rle_decoder_top.sv =====
// Top level: sprite cel run-length decoder.
//
//   channel   direction  handshake       payload
//   input     in         push / full     data_byte, cel_start
//   result    out        empty / pop     run_x, run_y, run_length, run_color,
//                                        is_fill, row_end, last_of_cel, clipped
//   config    in         cfg_we          cfg_wdata (loop_mirrored)
//
// One item per cycle sustained while pop is held; a result is registered in the item
// queue, then in the result queue. Rate is set by the column update in the back end.
// arst_n clears header state, counters and both queues; no clearing pass.
// full rises when the two-entry item queue is full; a stalled result queue
// backs up into it.
module sprite_cel_rle_decoder_top
	import srd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       cel_start,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] run_x,
	output logic [7:0] run_y,
	output logic [7:0] run_length,
	output logic [3:0] run_color,
	output logic       is_fill,
	output logic       row_end,
	output logic       last_of_cel,
	output logic       clipped,
	input  logic       cfg_we,
	input  logic       cfg_wdata
);

	logic loop_mirrored_q;
	logic cmd_push, cmd_valid, cmd_pop;
	cmd_t cmd_in, cmd_out;
	res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_mirrored_q <= 1'b0;
		end else if (cfg_we) begin
			loop_mirrored_q <= cfg_wdata;
		end
	end

	srd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.data_byte (data_byte),
		.cel_start (cel_start),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in)
	);

	srd_cmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_push),
		.cmd_in  (cmd_in),
		.full    (full),
		.pop     (cmd_pop),
		.valid   (cmd_valid),
		.cmd_out (cmd_out)
	);

	srd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.loop_mirrored (loop_mirrored_q),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd_out),
		.cmd_pop       (cmd_pop),
		.empty         (empty),
		.pop           (pop),
		.res           (res)
	);

	assign run_x       = res.run_x;
	assign run_y       = res.run_y;
	assign run_length  = res.run_length;
	assign run_color   = res.run_color;
	assign is_fill     = res.is_fill;
	assign row_end     = res.row_end;
	assign last_of_cel = res.last_of_cel;
	assign clipped     = res.clipped;

	a_fill_not_clipped: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(is_fill && clipped))
		else $error("fill item flagged as clipped");

	a_last_closes_row: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last_of_cel) |-> row_end)
		else $error("last_of_cel without row_end");

	a_fill_is_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (is_fill == row_end))
		else $error("is_fill and row_end disagree");

endmodule

// ===== verif/sprite_cel_rle_decoder_top_tb.sv =====
// Testbench: checks sprite_cel_rle_decoder_top run descriptors against a cycle-free decoder model.
module sprite_cel_rle_decoder_top_tb
	import srd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT  = 5000;
	localparam int RANDOM_ITEMS = 1200;

	logic       clk;
	logic       arst_n      = 1'b0;
	logic       push        = 1'b0;
	logic [7:0] data_byte   = 8'h00;
	logic       cel_start   = 1'b0;
	logic       pop         = 1'b0;
	logic       cfg_we      = 1'b0;
	logic       cfg_wdata   = 1'b0;
	logic       full;
	logic       empty;
	logic [7:0] run_x;
	logic [7:0] run_y;
	logic [7:0] run_length;
	logic [3:0] run_color;
	logic       is_fill;
	logic       row_end;
	logic       last_of_cel;
	logic       clipped;

	sprite_cel_rle_decoder_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.data_byte   (data_byte),
		.cel_start   (cel_start),
		.empty       (empty),
		.pop         (pop),
		.run_x       (run_x),
		.run_y       (run_y),
		.run_length  (run_length),
		.run_color   (run_color),
		.is_fill     (is_fill),
		.row_end     (row_end),
		.last_of_cel (last_of_cel),
		.clipped     (clipped),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// decoder model state
	phase_t     cel_phase   = PH_WIDTH;
	logic [7:0] cel_w       = 8'h00;
	logic [7:0] cel_h       = 8'h00;
	logic [3:0] clear_color = 4'h0;
	logic       flip_flag   = 1'b0;
	logic [7:0] cur_col     = 8'h00;
	logic [7:0] cur_row     = 8'h00;
	logic       mirror_cfg  = 1'b0;

	res_t runs_due[$];
	int   decoded_items = 0;
	int   errors        = 0;
	int   idle_cycles   = 0;
	int   burst_left    = 0;

	task automatic decode_byte(input logic [7:0] b, input logic s);
		res_t       r;
		logic [7:0] remain;
		logic [7:0] len;
		logic       fill;
		logic       clip;
		logic       last;
		if (s || cel_phase != PH_DONE)
			decoded_items++;
		if (s)
			cel_phase = PH_WIDTH;
		case (cel_phase)
			PH_WIDTH: begin
				cel_w = b;
				cur_col = 8'h00;
				cur_row = 8'h00;
				cel_phase = PH_HEIGHT;
			end
			PH_HEIGHT: begin
				cel_h = b;
				cel_phase = PH_FLAGS;
			end
			PH_FLAGS: begin
				clear_color = b[3:0];
				flip_flag = b[MIRROR_BIT];
				cur_col = 8'h00;
				cur_row = 8'h00;
				cel_phase = (cel_h == 8'h00) ? PH_DONE : PH_ROWS;
			end
			PH_ROWS: begin
				remain = cel_w - cur_col;
				clip = 1'b0;
				last = 1'b0;
				if (b != 8'h00) begin
					r.run_color = b[7:4];
					len = {4'h0, b[3:0]};
					fill = 1'b0;
					if (len > remain) begin
						len = remain;
						clip = 1'b1;
					end
				end else begin
					r.run_color = clear_color;
					len = remain;
					fill = 1'b1;
				end
				r.run_x = (flip_flag && mirror_cfg) ? cel_w - cur_col - len : cur_col;
				r.run_y = cur_row;
				r.run_length = len;
				r.is_fill = fill;
				r.row_end = fill;
				if (fill) begin
					last = ({1'b0, cur_row} + 9'd1 == {1'b0, cel_h});
					cur_row = cur_row + 8'd1;
					cur_col = 8'h00;
					if (last)
						cel_phase = PH_DONE;
				end else begin
					cur_col = cur_col + len;
				end
				r.last_of_cel = last;
				r.clipped = clip;
				runs_due.push_back(r);
			end
			default: ;
		endcase
	endtask

	// monitor: config copy, accepted items, result check, watchdog
	always @(posedge clk) begin
		res_t got;
		res_t want;
		logic moved;
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_we)
				mirror_cfg = cfg_wdata;
			if (push && !full) begin
				decode_byte(data_byte, cel_start);
				moved = 1'b1;
			end
			if (pop && !empty) begin
				moved = 1'b1;
				got = {run_x, run_y, run_length, run_color, is_fill, row_end,
					last_of_cel, clipped};
				if (runs_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected run: x=%0d y=%0d len=%0d col=%0h f=%b e=%b l=%b c=%b",
							got.run_x, got.run_y, got.run_length, got.run_color,
							got.is_fill, got.row_end, got.last_of_cel, got.clipped);
				end else begin
					want = runs_due.pop_front();
					if (got.run_x !== want.run_x || got.run_y !== want.run_y ||
						got.run_length !== want.run_length ||
						got.run_color !== want.run_color ||
						got.is_fill !== want.is_fill || got.row_end !== want.row_end ||
						got.last_of_cel !== want.last_of_cel ||
						got.clipped !== want.clipped) begin
						errors++;
						if (errors <= 10) begin
							$display("run mismatch: exp x=%0d y=%0d len=%0d col=%0h f=%b e=%b l=%b c=%b",
								want.run_x, want.run_y, want.run_length, want.run_color,
								want.is_fill, want.row_end, want.last_of_cel,
								want.clipped);
							$display("              got x=%0d y=%0d len=%0d col=%0h f=%b e=%b l=%b c=%b",
								got.run_x, got.run_y, got.run_length,
								got.run_color, got.is_fill, got.row_end,
								got.last_of_cel, got.clipped);
						end
					end
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("sprite_cel_rle_decoder_top regression: fail");
				$finish;
			end
		end
	end

	// receiver stall pattern
	bit [31:0] rx_cycle = 0;
	int        rx_hold  = 0;
	logic      rx_level = 1'b1;

	always @(posedge clk) begin
		rx_cycle++;
		if (rx_hold > 0) begin
			rx_hold--;
		end else begin
			case (rx_cycle[9:8])
				2'd0: rx_level = 1'b1;
				2'd1: rx_level = 1'($urandom_range(0, 1));
				2'd2: begin
					rx_level = !rx_level;
					rx_hold = $urandom_range(0, 7);
				end
				default: begin
					rx_level = !rx_level;
					rx_hold = rx_level ? $urandom_range(0, 2) : $urandom_range(5, 40);
				end
			endcase
		end
		pop <= rx_level;
	end

	task automatic send_byte(input logic [7:0] b, input logic s);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 12);
		end
		burst_left--;
		data_byte <= b;
		cel_start <= s;
		push <= 1'b1;
		do @(posedge clk); while (full);
	endtask

	task automatic drain_results(input int settle);
		push <= 1'b0;
		@(posedge clk);
		while (runs_due.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_mirror(input logic v);
		drain_results(4);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic test_no_start_header;
		write_mirror(1'b0);
		send_byte(8'd4, 1'b0);
		send_byte(8'd1, 1'b0);
		send_byte(8'h07, 1'b0);
		send_byte(8'h24, 1'b0);
		send_byte(8'h00, 1'b0);
	endtask

	task automatic test_runs_and_clipping;
		send_byte(8'd5, 1'b1);
		send_byte(8'd2, 1'b0);
		send_byte(8'h8A, 1'b0);
		send_byte(8'h13, 1'b0);
		send_byte(8'h2F, 1'b0);
		send_byte(8'h31, 1'b0);
		send_byte(8'h40, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
	endtask

	task automatic test_zero_sizes;
		send_byte(8'd9, 1'b1);
		send_byte(8'd0, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'd0, 1'b1);
		send_byte(8'd1, 1'b0);
		send_byte(8'h03, 1'b0);
		send_byte(8'h15, 1'b0);
		send_byte(8'h00, 1'b0);
	endtask

	task automatic test_mirroring;
		write_mirror(1'b1);
		send_byte(8'd255, 1'b1);
		send_byte(8'd2, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h12, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
	endtask

	task automatic send_cel(input logic broken);
		logic [7:0] w;
		logic [7:0] h;
		int         n;
		int         sel;
		sel = $urandom_range(0, 39);
		if (sel == 0) begin
			w = 8'($urandom_range(0, 3));
			h = 8'($urandom_range(100, 255));
		end else begin
			case ($urandom_range(0, 15))
				0:       w = 8'd0;
				1:       w = 8'd255;
				2:       w = 8'($urandom_range(16, 254));
				default: w = 8'($urandom_range(1, 15));
			endcase
			h = ($urandom_range(0, 11) == 0) ? 8'd0
				: ($urandom_range(0, 9) == 0) ? 8'($urandom_range(5, 12))
				: 8'($urandom_range(1, 4));
		end
		send_byte(w, 1'b1);
		send_byte(h, 1'b0);
		send_byte(8'($urandom_range(0, 255)), 1'b0);
		for (int r = 0; r < h; r++) begin
			n = (sel == 0) ? $urandom_range(0, 1) : $urandom_range(0, w / 6 + 2);
			if (n > 20)
				n = 20;
			repeat (n) send_byte(8'($urandom_range(1, 255)), 1'b0);
			if (broken && r == h / 2)
				return;
			send_byte(8'h00, 1'b0);
		end
		repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)), 1'b0);
	endtask

	task automatic test_random_stream;
		int base;
		int next_cfg;
		base = decoded_items;
		next_cfg = 150;
		while (decoded_items - base < RANDOM_ITEMS) begin
			if (decoded_items - base >= next_cfg) begin
				write_mirror(1'($urandom_range(0, 1)));
				next_cfg += $urandom_range(150, 250);
			end
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(1, 6))
					send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
			else
				send_cel($urandom_range(0, 7) == 0);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_no_start_header();
		test_runs_and_clipping();
		test_zero_sizes();
		test_mirroring();
		test_random_stream();
		drain_results(8);
		if (errors == 0 && runs_due.size() == 0)
			$display("sprite_cel_rle_decoder_top regression: pass");
		else
			$display("sprite_cel_rle_decoder_top regression: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/srd_pkg.sv
rtl/srd_front.sv
rtl/srd_cmd_queue.sv
rtl/srd_back.sv
rtl/sprite_cel_rle_decoder_top.sv
verif/sprite_cel_rle_decoder_top_tb.sv
